### sv/sfcd_pkg.sv
// ----------------------------------------------------------------------------
// sfcd_pkg: shared types and constants of the serial frame command decoder
// Holds the transfer payload structs, the decoder state, the command codes
// and the duty clamp used at reset and on configuration writes.
// ----------------------------------------------------------------------------
package sfcd_pkg;

    // Input item kinds.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_DEVICE_ID    = 1'b0;
    localparam logic CFG_INITIAL_DUTY = 1'b1;

    // Frame markers and addresses.
    localparam logic [7:0] START_MARK = 8'h69;
    localparam logic [7:0] BROADCAST  = 8'hFF;
    localparam logic [7:0] PAR_ZERO   = 8'h00;
    localparam logic [7:0] PAR_HOLD   = 8'hFF;

    // Duty limits for the stored start duty.
    localparam logic [7:0] DUTY_LOW  = 8'd25;
    localparam logic [7:0] DUTY_HIGH = 8'd68;

    // Command codes.
    localparam logic [7:0] CMD_DUTY    = 8'd1;
    localparam logic [7:0] CMD_SET_ID  = 8'd5;
    localparam logic [7:0] CMD_SOL     = 8'd6;
    localparam logic [7:0] CMD_HALT    = 8'd9;
    localparam logic [7:0] CMD_RESUME  = 8'd13;
    localparam logic [7:0] CMD_SET_PWM = 8'd60;

    // One received item.
    typedef struct packed {
        logic       op;
        logic [7:0] byte_value;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [7:0] servo_duty;
        logic       solenoid_on;
        logic       pins_driven;
        logic       miso_driven;
        logic       frame_taken;
        logic       store_id;
        logic       store_duty;
        logic [7:0] store_value;
        logic       busy_res;
    } t_out_item;

    // Decoder state carried from item to item.
    typedef struct packed {
        logic [3:0][7:0] frame_bytes;
        logic [7:0]      byte_position;
        logic [7:0]      pulse_ticks_left;
        logic [7:0]      duty_now;
        logic            solenoid_level;
        logic            drive_on;
        logic            miso_on;
    } t_state;

    // Replace a start duty outside the allowed range by the low limit.
    function automatic logic [7:0] clamp_duty(input logic [7:0] d);
        logic [7:0] res;
        res = ((d >= DUTY_LOW) && (d <= DUTY_HIGH)) ? d : DUTY_LOW;
        return res;
    endfunction

endpackage

### sv/spi_frame_command_decoder_core.sv
// ----------------------------------------------------------------------------
// spi_frame_command_decoder_core: serial frame command decoder
// Path: the input register, then decode into the result register.
// Throughput: one item per cycle unless the output stalls; while a result
// waits, the input register can still take one item before the input stalls.
// Reset (i_rst_n low, synchronous): frame store and position cleared, no
// pulse, duty 25, solenoid low, pins and data-out driven, id 0.
// ----------------------------------------------------------------------------
module spi_frame_command_decoder_core
    import sfcd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_item,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic       r_in_valid;
    t_in_item   r_in_item;
    logic       r_out_valid;
    t_out_item  r_out_item;
    t_state     r_state;
    t_state     n_state;
    t_state     n_state_upd;
    t_out_item  n_result;
    logic [7:0] r_device_id;
    logic       w_step;
    logic       w_take;

    // The decode step fires when the result register is free or drains now.
    assign w_step     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign w_take     = i_in_valid && !o_in_stall;
    assign o_in_stall = r_in_valid && !w_step;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    sfcd_step u_step (
        .i_state     (r_state),
        .i_device_id (r_device_id),
        .i_item      (r_in_item),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_item <= i_in_item;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_item <= n_result;
        end
    end

    // Next decoder state: the step result (or the held state), with a start duty write on top.
    always_comb begin
        n_state_upd = w_step ? n_state : r_state;
        if (i_cfg_we && (i_cfg_index == CFG_INITIAL_DUTY)) begin
            n_state_upd.duty_now = clamp_duty(i_cfg_data);
        end
    end

    // Decoder state and configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.frame_bytes      <= '0;
            r_state.byte_position    <= 8'd0;
            r_state.pulse_ticks_left <= 8'd0;
            r_state.duty_now         <= clamp_duty(DUTY_LOW);
            r_state.solenoid_level   <= 1'b0;
            r_state.drive_on         <= 1'b1;
            r_state.miso_on          <= 1'b1;
            r_device_id              <= 8'd0;
        end else begin
            r_state <= n_state_upd;
            if (i_cfg_we && (i_cfg_index == CFG_DEVICE_ID)) begin
                r_device_id <= i_cfg_data;
            end
        end
    end

endmodule

### sv/sfcd_step.sv
// ----------------------------------------------------------------------------
// sfcd_step: one decoder step
// Given the current state, the device id and one item, computes the next
// state and the result item. Purely combinational.
// ----------------------------------------------------------------------------
module sfcd_step
    import sfcd_pkg::*;
(
    input  t_state     i_state,
    input  logic [7:0] i_device_id,
    input  t_in_item   i_item,
    output t_state     o_state,
    output t_out_item  o_result
);

    logic [7:0] w_addr;
    logic [7:0] w_cmd;
    logic [7:0] w_par;
    logic [7:0] w_sum;
    logic       w_frame_ok;
    t_state     w_st;
    logic       w_taken;
    logic       w_st_id;
    logic       w_st_duty;
    logic [7:0] w_st_val;

    // Frame fields as seen after this byte has been stored.
    assign w_addr = w_st.frame_bytes[0];
    assign w_cmd  = w_st.frame_bytes[1];
    assign w_par  = w_st.frame_bytes[2];
    assign w_sum  = w_addr + w_cmd + w_par;
    assign w_frame_ok = (w_st.byte_position[7:2] != 6'd0)
                     && (w_sum == w_st.frame_bytes[3])
                     && ((w_addr == BROADCAST) || (w_addr == i_device_id));

    // Byte collection and tick handling.
    always_comb begin
        w_st = i_state;
        if (i_item.op == OP_TICK) begin
            if (i_state.pulse_ticks_left != 8'd0) begin
                w_st.pulse_ticks_left = i_state.pulse_ticks_left - 8'd1;
                if (i_state.pulse_ticks_left == 8'd1) begin
                    w_st.solenoid_level = 1'b0;
                end
            end
        end else if (i_state.pulse_ticks_left == 8'd0) begin
            if (i_item.byte_value == START_MARK) begin
                w_st.byte_position = 8'd0;
            end else begin
                w_st.frame_bytes[i_state.byte_position[1:0]] = i_item.byte_value;
                w_st.byte_position = i_state.byte_position + 8'd1;
            end
        end
    end

    // Command execution on a valid frame for this unit.
    always_comb begin
        o_state   = w_st;
        w_taken   = 1'b0;
        w_st_id   = 1'b0;
        w_st_duty = 1'b0;
        w_st_val  = 8'd0;
        if ((i_item.op == OP_BYTE) && (i_state.pulse_ticks_left == 8'd0) && w_frame_ok) begin
            w_taken = 1'b1;
            unique case (w_cmd)
                CMD_DUTY: begin
                    o_state.duty_now = w_par;
                end
                CMD_SOL: begin
                    if (w_par == PAR_ZERO) begin
                        o_state.solenoid_level = 1'b0;
                    end else begin
                        o_state.solenoid_level = 1'b1;
                        if (w_par != PAR_HOLD) begin
                            o_state.pulse_ticks_left = w_par;
                        end
                    end
                end
                CMD_SET_ID: begin
                    w_st_id  = 1'b1;
                    w_st_val = w_par;
                end
                CMD_SET_PWM: begin
                    w_st_duty = 1'b1;
                    w_st_val  = w_par;
                end
                CMD_HALT: begin
                    o_state.solenoid_level = 1'b0;
                    o_state.drive_on       = 1'b0;
                    o_state.miso_on        = 1'b0;
                end
                CMD_RESUME: begin
                    o_state.drive_on = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Result item from the state after this step.
    always_comb begin
        o_result.servo_duty  = o_state.duty_now;
        o_result.solenoid_on = o_state.solenoid_level;
        o_result.pins_driven = o_state.drive_on;
        o_result.miso_driven = o_state.miso_on;
        o_result.frame_taken = w_taken;
        o_result.store_id    = w_st_id;
        o_result.store_duty  = w_st_duty;
        o_result.store_value = w_st_val;
        o_result.busy_res    = (o_state.pulse_ticks_left != 8'd0);
    end

endmodule
